// ===== hw/rtl/u8sd_pkg.sv =====
package u8sd_pkg;

  // Width of the internal character counter; char_count_o reports at most 16 bits.
  localparam int COUNT_WIDTH  = 16;
  localparam int CHAR_COUNT_W = 16;
  localparam int CP_W         = 21;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [1:0] KIND_CHAR = 2'd0;
  localparam logic [1:0] KIND_END  = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_STRAY     = 2'd1;
  localparam logic [1:0] ERR_BAD_LEAD  = 2'd2;
  localparam logic [1:0] ERR_TRUNCATED = 2'd3;

  typedef enum logic [2:0] {
    CLS_END,
    CLS_ASCII,
    CLS_CONT,
    CLS_LEAD2,
    CLS_LEAD3,
    CLS_LEAD4,
    CLS_BAD
  } cls_e;

  typedef struct packed {
    cls_e       cls;
    logic [7:0] data;
  } op_t;

endpackage

// ===== hw/rtl/u8sd_front.sv =====
module u8sd_front (
  input  logic [7:0]     byte_i,
  output u8sd_pkg::op_t  op_o
);

  u8sd_pkg::cls_e cls;

  always_comb begin
    if (byte_i == 8'h00) begin
      cls = u8sd_pkg::CLS_END;
    end else if (byte_i[7] == 1'b0) begin
      cls = u8sd_pkg::CLS_ASCII;
    end else if (byte_i[7:6] == 2'b10) begin
      cls = u8sd_pkg::CLS_CONT;
    end else if (byte_i[7:5] == 3'b110) begin
      cls = u8sd_pkg::CLS_LEAD2;
    end else if (byte_i[7:4] == 4'b1110) begin
      cls = u8sd_pkg::CLS_LEAD3;
    end else if (byte_i[7:3] == 5'b11110) begin
      cls = u8sd_pkg::CLS_LEAD4;
    end else begin
      cls = u8sd_pkg::CLS_BAD;
    end
  end

  assign op_o.cls  = cls;
  assign op_o.data = byte_i;

endmodule

// ===== hw/rtl/u8sd_queue.sv =====
module u8sd_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  u8sd_pkg::op_t push_data_i,
  input  logic          pop_i,
  output u8sd_pkg::op_t head_o,
  output logic          empty_o,
  output logic          full_o
);

  localparam int PtrW = $clog2(u8sd_pkg::QUEUE_DEPTH);

  u8sd_pkg::op_t mem_q [u8sd_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]   count_q, count_d;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == (PtrW+1)'(u8sd_pkg::QUEUE_DEPTH));
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== hw/rtl/u8sd_back.sv =====
module u8sd_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  u8sd_pkg::op_t                       op_i,
  input  logic                                op_avail_i,
  output logic                                op_pop_o,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [1:0]                          kind_o,
  output logic [u8sd_pkg::CP_W-1:0]           code_point_o,
  output logic [2:0]                          byte_len_o,
  output logic [1:0]                          error_code_o,
  output logic [u8sd_pkg::CHAR_COUNT_W-1:0]   char_count_o,
  output logic                                string_ok_o
);

  localparam int CW = u8sd_pkg::COUNT_WIDTH;

  logic [u8sd_pkg::CP_W-1:0] partial_q, partial_d;
  logic [1:0]                left_q, left_d;
  logic [2:0]                len_q, len_d;
  logic [CW-1:0]             seen_q, seen_d;
  logic                      err_q, err_d;

  logic                      valid_q, valid_d;
  logic [1:0]                kind_q, kind_d;
  logic [u8sd_pkg::CP_W-1:0] cp_q, cp_d;
  logic [2:0]                blen_q, blen_d;
  logic [1:0]                ecode_q, ecode_d;
  logic [u8sd_pkg::CHAR_COUNT_W-1:0] cnt_q, cnt_d;
  logic                      ok_q, ok_d;

  logic                      emit;
  logic [u8sd_pkg::CP_W-1:0] shifted;
  logic [CW-1:0]             seen_inc;
  logic [31:0]               seen_ext;
  logic                      cut;

  // Advance whenever the output slot is free or being drained this cycle.
  assign op_pop_o = op_avail_i && (!valid_q || !out_stall_i);

  assign shifted  = {partial_q[u8sd_pkg::CP_W-7:0], op_i.data[5:0]};
  assign seen_inc = (seen_q == {CW{1'b1}}) ? seen_q : seen_q + 1'b1;
  assign seen_ext = 32'(seen_q);
  assign cut      = (left_q != 2'd0);

  always_comb begin
    partial_d = partial_q;
    left_d    = left_q;
    len_d     = len_q;
    seen_d    = seen_q;
    err_d     = err_q;
    emit      = 1'b0;
    kind_d    = kind_q;
    cp_d      = cp_q;
    blen_d    = blen_q;
    ecode_d   = ecode_q;
    cnt_d     = cnt_q;
    ok_d      = ok_q;

    if (op_pop_o) begin
      emit    = 1'b1;
      kind_d  = u8sd_pkg::KIND_CHAR;
      cp_d    = '0;
      blen_d  = '0;
      ecode_d = u8sd_pkg::ERR_NONE;
      cnt_d   = '0;
      ok_d    = 1'b0;

      if (op_i.cls == u8sd_pkg::CLS_END) begin
        kind_d  = u8sd_pkg::KIND_END;
        ecode_d = cut ? u8sd_pkg::ERR_TRUNCATED : u8sd_pkg::ERR_NONE;
        cnt_d   = (seen_ext > 32'h0000_FFFF) ? {u8sd_pkg::CHAR_COUNT_W{1'b1}}
                                             : seen_ext[u8sd_pkg::CHAR_COUNT_W-1:0];
        ok_d    = !(cut || err_q);
        partial_d = '0;
        left_d    = '0;
        len_d     = '0;
        seen_d    = '0;
        err_d     = 1'b0;
      end else if (cut) begin
        // Any nonzero byte inside an open character counts as continuation.
        left_d    = left_q - 1'b1;
        partial_d = shifted;
        if (left_q == 2'd1) begin
          cp_d      = shifted;
          blen_d    = len_q;
          seen_d    = seen_inc;
          partial_d = '0;
          len_d     = '0;
        end else begin
          emit = 1'b0;
        end
      end else begin
        case (op_i.cls)
          u8sd_pkg::CLS_ASCII: begin
            cp_d   = u8sd_pkg::CP_W'(op_i.data);
            blen_d = 3'd1;
            seen_d = seen_inc;
          end
          u8sd_pkg::CLS_CONT: begin
            kind_d  = u8sd_pkg::KIND_ERR;
            ecode_d = u8sd_pkg::ERR_STRAY;
            err_d   = 1'b1;
          end
          u8sd_pkg::CLS_LEAD2: begin
            emit      = 1'b0;
            partial_d = u8sd_pkg::CP_W'(op_i.data[4:0]);
            left_d    = 2'd1;
            len_d     = 3'd2;
          end
          u8sd_pkg::CLS_LEAD3: begin
            emit      = 1'b0;
            partial_d = u8sd_pkg::CP_W'(op_i.data[3:0]);
            left_d    = 2'd2;
            len_d     = 3'd3;
          end
          u8sd_pkg::CLS_LEAD4: begin
            emit      = 1'b0;
            partial_d = u8sd_pkg::CP_W'(op_i.data[2:0]);
            left_d    = 2'd3;
            len_d     = 3'd4;
          end
          default: begin
            kind_d  = u8sd_pkg::KIND_ERR;
            ecode_d = u8sd_pkg::ERR_BAD_LEAD;
            err_d   = 1'b1;
          end
        endcase
      end
    end

    if (emit) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q <= '0;
      left_q    <= '0;
      len_q     <= '0;
      seen_q    <= '0;
      err_q     <= 1'b0;
      valid_q   <= 1'b0;
    end else begin
      partial_q <= partial_d;
      left_q    <= left_d;
      len_q     <= len_d;
      seen_q    <= seen_d;
      err_q     <= err_d;
      valid_q   <= valid_d;
    end
  end

  // Hold the result fields unless a new result is loaded.
  always_ff @(posedge clk_i) begin
    if (emit) begin
      kind_q  <= kind_d;
      cp_q    <= cp_d;
      blen_q  <= blen_d;
      ecode_q <= ecode_d;
      cnt_q   <= cnt_d;
      ok_q    <= ok_d;
    end
  end

  assign out_valid_o  = valid_q;
  assign kind_o       = kind_q;
  assign code_point_o = cp_q;
  assign byte_len_o   = blen_q;
  assign error_code_o = ecode_q;
  assign char_count_o = cnt_q;
  assign string_ok_o  = ok_q;

endmodule

// ===== hw/rtl/utf8_stream_decoder_unit.sv =====
// UTF-8 stream decoder: takes one byte per transaction and returns at most one
// result per byte (a decoded character, an end-of-string summary on a zero
// byte, or an error). It sustains one byte per cycle while the output is not
// stalled: a classifier feeds a two-entry queue, and the decode stage pops one
// entry per cycle, while the output register is free or being drained, into a
// single output register. Input stall rises only when the queue is full, which
// can happen when the output stalls while bytes keep arriving. Continuation
// bytes are not checked; the character count saturates.
module utf8_stream_decoder_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [7:0]                        in_byte_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [1:0]                        kind_o,
  output logic [u8sd_pkg::CP_W-1:0]         code_point_o,
  output logic [2:0]                        byte_len_o,
  output logic [1:0]                        error_code_o,
  output logic [u8sd_pkg::CHAR_COUNT_W-1:0] char_count_o,
  output logic                              string_ok_o
);

  u8sd_pkg::op_t front_op;
  u8sd_pkg::op_t head_op;
  logic          q_empty;
  logic          q_full;
  logic          q_pop;
  logic          q_push;

  assign in_stall_o = q_full;
  assign q_push     = in_valid_i && !q_full;

  u8sd_front u_front (
    .byte_i (in_byte_i),
    .op_o   (front_op)
  );

  u8sd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (front_op),
    .pop_i       (q_pop),
    .head_o      (head_op),
    .empty_o     (q_empty),
    .full_o      (q_full)
  );

  u8sd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .op_i         (head_op),
    .op_avail_i   (!q_empty),
    .op_pop_o     (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .kind_o       (kind_o),
    .code_point_o (code_point_o),
    .byte_len_o   (byte_len_o),
    .error_code_o (error_code_o),
    .char_count_o (char_count_o),
    .string_ok_o  (string_ok_o)
  );

  a_char_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == u8sd_pkg::KIND_CHAR |->
      byte_len_o != 3'd0 && byte_len_o <= 3'd4 && error_code_o == u8sd_pkg::ERR_NONE
      && char_count_o == '0)
    else $error("character result with bad fields");

  a_non_end_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != u8sd_pkg::KIND_END |-> !string_ok_o)
    else $error("string_ok set on non-end result");

  a_truncated_fails: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == u8sd_pkg::KIND_END && error_code_o == u8sd_pkg::ERR_TRUNCATED
      |-> !string_ok_o && byte_len_o == 3'd0 && code_point_o == '0)
    else $error("truncated string reported as ok");

  a_stalled_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(kind_o) && $stable(code_point_o) && $stable(byte_len_o)
      && $stable(error_code_o) && $stable(char_count_o) && $stable(string_ok_o))
    else $error("stalled result changed");

endmodule

// ===== test/tb_utf8_stream_decoder_unit.sv =====
module tb_utf8_stream_decoder_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int N_DIR_ROWS     = 25;

  typedef struct packed {
    logic [1:0]                        kind;
    logic [u8sd_pkg::CP_W-1:0]         code_point;
    logic [2:0]                        byte_len;
    logic [1:0]                        error_code;
    logic [u8sd_pkg::CHAR_COUNT_W-1:0] char_count;
    logic                              string_ok;
  } u8_result_t;

  typedef struct packed {
    logic [7:0] data;
    bit         typed;
    u8_result_t want;
  } stim_row_t;

  // Rows with typed = 1 carry their own expected result; the rest go to the decoder model.
  localparam stim_row_t DIR_ROWS [N_DIR_ROWS] = '{
    '{8'h00, 1'b1, '{u8sd_pkg::KIND_END, 21'd0, 3'd0, u8sd_pkg::ERR_NONE, 16'd0, 1'b1}},
    '{8'h7F, 1'b1, '{u8sd_pkg::KIND_CHAR, 21'h7F, 3'd1, u8sd_pkg::ERR_NONE, 16'd0, 1'b0}},
    '{8'h01, 1'b1, '{u8sd_pkg::KIND_CHAR, 21'h01, 3'd1, u8sd_pkg::ERR_NONE, 16'd0, 1'b0}},
    '{8'h80, 1'b1, '{u8sd_pkg::KIND_ERR, 21'd0, 3'd0, u8sd_pkg::ERR_STRAY, 16'd0, 1'b0}},
    '{8'hFF, 1'b1, '{u8sd_pkg::KIND_ERR, 21'd0, 3'd0, u8sd_pkg::ERR_BAD_LEAD, 16'd0, 1'b0}},
    '{8'hF8, 1'b1, '{u8sd_pkg::KIND_ERR, 21'd0, 3'd0, u8sd_pkg::ERR_BAD_LEAD, 16'd0, 1'b0}},
    '{8'hBF, 1'b1, '{u8sd_pkg::KIND_ERR, 21'd0, 3'd0, u8sd_pkg::ERR_STRAY, 16'd0, 1'b0}},
    '{8'h00, 1'b1, '{u8sd_pkg::KIND_END, 21'd0, 3'd0, u8sd_pkg::ERR_NONE, 16'd2, 1'b0}},
    '{8'hC2, 1'b0, '0},
    '{8'hA9, 1'b0, '0},
    '{8'hDF, 1'b0, '0},
    '{8'hBF, 1'b0, '0},
    '{8'hE2, 1'b0, '0},
    '{8'h82, 1'b0, '0},
    '{8'hAC, 1'b0, '0},
    '{8'hF7, 1'b0, '0},
    '{8'hBF, 1'b0, '0},
    '{8'hBF, 1'b0, '0},
    '{8'hBF, 1'b1, '{u8sd_pkg::KIND_CHAR, 21'h1FFFFF, 3'd4, u8sd_pkg::ERR_NONE, 16'd0, 1'b0}},
    '{8'hF0, 1'b0, '0},
    '{8'h41, 1'b0, '0},
    '{8'hFF, 1'b0, '0},
    '{8'h01, 1'b0, '0},
    '{8'hE0, 1'b0, '0},
    '{8'h00, 1'b1, '{u8sd_pkg::KIND_END, 21'd0, 3'd0, u8sd_pkg::ERR_TRUNCATED, 16'd5, 1'b0}}
  };

  logic                              clk_i       = 1'b0;
  logic                              rst_ni      = 1'b0;
  logic                              in_valid_i  = 1'b0;
  logic [7:0]                        in_byte_i   = 8'h00;
  logic                              out_stall_i = 1'b0;
  logic                              in_stall_o;
  logic                              out_valid_o;
  logic [1:0]                        kind_o;
  logic [u8sd_pkg::CP_W-1:0]         code_point_o;
  logic [2:0]                        byte_len_o;
  logic [1:0]                        error_code_o;
  logic [u8sd_pkg::CHAR_COUNT_W-1:0] char_count_o;
  logic                              string_ok_o;

  utf8_stream_decoder_unit DUT (.*);

  always #10 clk_i = ~clk_i;

  // Decoder model state
  logic [u8sd_pkg::CP_W-1:0]        part_value    = '0;
  logic [1:0]                       conts_left    = '0;
  logic [2:0]                       open_len      = '0;
  logic [u8sd_pkg::COUNT_WIDTH-1:0] char_total    = '0;
  logic                             string_failed = 1'b0;

  u8_result_t pending_results [$];
  int         send_idle_pct  = 0;
  int         recv_stall_pct = 0;
  int         bytes_accepted = 0;
  int         mismatches     = 0;
  int         idle_cycles    = 0;

  function automatic void close_char(output u8_result_t r);
    r = '0;
    r.kind       = u8sd_pkg::KIND_CHAR;
    r.code_point = part_value;
    r.byte_len   = open_len;
    if (char_total != '1) char_total++;
    part_value = '0;
    conts_left = '0;
    open_len   = '0;
  endfunction

  function automatic void flag_error(input logic [1:0] code, output u8_result_t r);
    r = '0;
    r.kind       = u8sd_pkg::KIND_ERR;
    r.error_code = code;
    string_failed = 1'b1;
  endfunction

  function automatic bit decode_byte(input logic [7:0] b, output u8_result_t r);
    bit cut;
    r = '0;
    if (b == 8'h00) begin
      cut = (conts_left != 0);
      r.kind       = u8sd_pkg::KIND_END;
      r.error_code = cut ? u8sd_pkg::ERR_TRUNCATED : u8sd_pkg::ERR_NONE;
      r.char_count = (64'(char_total) > 64'({u8sd_pkg::CHAR_COUNT_W{1'b1}})) ?
                     {u8sd_pkg::CHAR_COUNT_W{1'b1}} : u8sd_pkg::CHAR_COUNT_W'(char_total);
      r.string_ok  = !(cut || string_failed);
      part_value    = '0;
      conts_left    = '0;
      open_len      = '0;
      char_total    = '0;
      string_failed = 1'b0;
      return 1'b1;
    end
    // Any nonzero byte inside an open character is taken as a continuation.
    if (conts_left != 0) begin
      part_value = {part_value[u8sd_pkg::CP_W-7:0], b[5:0]};
      conts_left--;
      if (conts_left == 0) begin
        close_char(r);
        return 1'b1;
      end
      return 1'b0;
    end
    casez (b)
      8'b0???????: begin
        part_value = u8sd_pkg::CP_W'(b);
        open_len   = 3'd1;
        close_char(r);
        return 1'b1;
      end
      8'b10??????: begin
        flag_error(u8sd_pkg::ERR_STRAY, r);
        return 1'b1;
      end
      8'b110?????: begin
        part_value = u8sd_pkg::CP_W'(b[4:0]);
        conts_left = 2'd1;
        open_len   = 3'd2;
        return 1'b0;
      end
      8'b1110????: begin
        part_value = u8sd_pkg::CP_W'(b[3:0]);
        conts_left = 2'd2;
        open_len   = 3'd3;
        return 1'b0;
      end
      8'b11110???: begin
        part_value = u8sd_pkg::CP_W'(b[2:0]);
        conts_left = 2'd3;
        open_len   = 3'd4;
        return 1'b0;
      end
      default: begin
        flag_error(u8sd_pkg::ERR_BAD_LEAD, r);
        return 1'b1;
      end
    endcase
  endfunction

  task automatic note_failure(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  function automatic string fmt_result(input u8_result_t r);
    return $sformatf("kind=%0d cp=%h len=%0d err=%0d count=%0d ok=%0d", r.kind,
                     r.code_point, r.byte_len, r.error_code, r.char_count, r.string_ok);
  endfunction

  task automatic send_byte(input logic [7:0] data, input bit typed = 1'b0,
                           input u8_result_t want = '0);
    u8_result_t r;
    bit         has_result;
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_byte_i  = data;
    do @(posedge clk_i); while (in_stall_o);
    has_result = decode_byte(data, r);
    if (has_result) pending_results.push_back(typed ? want : r);
    bytes_accepted++;
  endtask

  // Hold the sender off until every outstanding result has come back.
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_char(input int len, input int n_cont);
    logic [7:0] lead;
    case (len)
      1:       lead = 8'($urandom_range(1, 127));
      2:       lead = 8'hC0 | 8'($urandom_range(0, 31));
      3:       lead = 8'hE0 | 8'($urandom_range(0, 15));
      default: lead = 8'hF0 | 8'($urandom_range(0, 7));
    endcase
    send_byte(lead);
    repeat (n_cont) begin
      if ($urandom_range(9) == 0) send_byte(8'($urandom_range(1, 255)));
      else send_byte(8'h80 | 8'($urandom_range(0, 63)));
    end
  endtask

  task automatic send_random_string();
    int n_chars;
    int pick;
    int len;
    n_chars = $urandom_range(0, 12);
    repeat (n_chars) begin
      pick = $urandom_range(99);
      if (pick < 80) begin
        len = $urandom_range(1, 4);
        send_char(len, len - 1);
      end else if (pick < 86) begin
        send_byte(8'h80 | 8'($urandom_range(0, 63)));
      end else if (pick < 91) begin
        send_byte(8'hF8 | 8'($urandom_range(0, 7)));
      end else if (pick < 95) begin
        // cut a character short
        len = $urandom_range(2, 4);
        send_char(len, $urandom_range(0, len - 2));
        send_byte(8'h00);
      end else begin
        send_byte(8'($urandom_range(0, 255)));
      end
    end
    send_byte(8'h00);
  endtask

  task automatic run_random(input int target);
    while (bytes_accepted < target) begin
      if ($urandom_range(14) == 0) drain_results();
      send_random_string();
    end
    drain_results();
  endtask

  always @(negedge clk_i) begin
    out_stall_i = ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin : check_results
    u8_result_t got;
    u8_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{kind_o, code_point_o, byte_len_o, error_code_o, char_count_o, string_ok_o};
      if (pending_results.size() == 0) begin
        note_failure({"unexpected result: ", fmt_result(got)});
      end else begin
        want = pending_results.pop_front();
        if (got !== want)
          note_failure({"mismatch: expected ", fmt_result(want), " got ", fmt_result(got)});
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_idle_pct  = 25;
    recv_stall_pct = 72;
    for (int i = 0; i < N_DIR_ROWS; i++)
      send_byte(DIR_ROWS[i].data, DIR_ROWS[i].typed, DIR_ROWS[i].want);
    run_random(600);

    send_idle_pct  = 72;
    recv_stall_pct = 25;
    run_random(1150);

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_random(1700);

    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
